// File: rtl/phrt_pkg.sv
// peer health rank table: shared types, codes and helper functions
// no dependencies; imported by every module of the block
package phrt_pkg;

    localparam int TABLE_DEPTH_DEF  = 16;
    localparam int MAX_EXCLUDES_DEF = 3;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_SUCCESS = 3'd1;
    localparam logic [2:0] OP_FAILURE = 3'd2;
    localparam logic [2:0] OP_PICK    = 3'd3;
    localparam logic [2:0] OP_PROBE   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;

    localparam logic signed [3:0] RANK_MIN  = -4'sd5;
    localparam logic signed [3:0] RANK_MAX  = 4'sd5;
    localparam logic signed [3:0] RANK_ONE  = 4'sd1;
    localparam logic signed [3:0] RANK_ZERO = 4'sd0;

    localparam logic [17:0] PROBE_STEP_MS = 18'd30000;

    localparam int RND_W = 32;

    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] endpoint;
        logic [1:0]  exclude_count;
        logic [47:0] exclude_a;
        logic [47:0] exclude_b;
        logic [47:0] exclude_c;
        logic [31:0] random_value;
    } phrt_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [47:0]        chosen_endpoint;
        logic signed [3:0]  new_rank;
        logic               probe_now;
        logic [17:0]        probe_delay_ms;
        logic               cancel_probe;
        logic               start_announce;
    } phrt_rsp_t;

    typedef struct packed {
        logic [47:0]        endpoint;
        logic signed [3:0]  rank;
        logic               pending;
    } phrt_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COUNT,
        S_MOD,
        S_SELECT,
        S_FINISH
    } phrt_state_t;

    // (1 - rank) * 30 s for rank in -5..0
    function automatic logic [17:0] probe_delay(input logic signed [3:0] rank);
        logic [3:0] mult;
        mult = 4'd1 - rank;
        return 18'(mult) * PROBE_STEP_MS;
    endfunction

endpackage

// File: rtl/phrt_mem.sv
// entry store: endpoint, rank and probe-pending per table slot
// single write port, one registered read port; uses phrt_pkg
module phrt_mem #(
    parameter int DEPTH = phrt_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  phrt_pkg::phrt_entry_t  wr_entry,
    input  logic [IDX_W-1:0]       rd_addr,
    output phrt_pkg::phrt_entry_t  rd_entry
);
    import phrt_pkg::*;

    phrt_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry <= mem[rd_addr];
    end

endmodule

// File: rtl/phrt_div.sv
// radix-2 restoring modulo unit, one dividend bit per cycle
// remainder valid with the done pulse; uses phrt_pkg
module phrt_div #(
    parameter int CNT_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [31:0]             dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic [CNT_W-1:0]        remainder
);
    import phrt_pkg::*;

    localparam int STEP_W = $clog2(RND_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [31:0]        dvd_reg, dvd_next;
    logic [CNT_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[31]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(RND_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = CNT_W'(trial);
            end
            dvd_next  = {dvd_reg[30:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/phrt_ctrl.sv
// sequencer: table scans, pick selection, read-modify-write and result register
// drives phrt_mem and phrt_div; uses phrt_pkg
module phrt_ctrl #(
    parameter int DEPTH        = phrt_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_EXCLUDES = phrt_pkg::MAX_EXCLUDES_DEF,
    parameter int IDX_W        = $clog2(DEPTH),
    parameter int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  phrt_pkg::phrt_req_t    req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output phrt_pkg::phrt_rsp_t    rsp,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output phrt_pkg::phrt_entry_t  wr_entry,
    output logic [IDX_W-1:0]       rd_addr,
    input  phrt_pkg::phrt_entry_t  rd_entry,
    output logic                   div_start,
    output logic [31:0]            div_dividend,
    output logic [CNT_W-1:0]       div_divisor,
    input  logic                   div_done,
    input  logic [CNT_W-1:0]       div_rem
);
    import phrt_pkg::*;

    localparam logic EXCL_EN1 = (MAX_EXCLUDES >= 2);
    localparam logic EXCL_EN2 = (MAX_EXCLUDES >= 3);

    phrt_state_t        state_reg, state_next;
    phrt_req_t          item_reg, item_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   target_reg, target_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    phrt_entry_t        hit_reg, hit_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               announcing_reg, announcing_next;
    phrt_rsp_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               issue;
    logic               scan_end;
    logic               match;
    logic               excluded;
    logic               eligible;
    logic               table_full;
    logic signed [3:0]  rank_work;
    phrt_rsp_t          result;

    assign issue = ((state_reg == S_SCAN) || (state_reg == S_COUNT) || (state_reg == S_SELECT))
                   && (rd_idx_reg < count_reg);
    assign scan_end   = !chk_valid_reg && !(rd_idx_reg < count_reg);
    assign match      = chk_valid_reg && (rd_entry.endpoint == item_reg.endpoint);
    assign excluded   = ((item_reg.exclude_count >= 2'd1) && (rd_entry.endpoint == item_reg.exclude_a))
                     || (EXCL_EN1 && (item_reg.exclude_count >= 2'd2)
                         && (rd_entry.endpoint == item_reg.exclude_b))
                     || (EXCL_EN2 && (item_reg.exclude_count == 2'd3)
                         && (rd_entry.endpoint == item_reg.exclude_c));
    assign eligible   = chk_valid_reg && ($signed(rd_entry.rank) > RANK_ZERO) && !excluded;
    assign table_full = (count_reg == CNT_W'(DEPTH));
    assign rd_addr    = rd_idx_reg[IDX_W-1:0];

    // result and write-back of the finishing item
    always_comb
    begin
        result    = '0;
        result.chosen_endpoint = item_reg.endpoint;
        wr_en     = 1'b0;
        wr_addr   = hit_idx_reg;
        wr_entry  = hit_reg;
        rank_work = hit_reg.rank;
        unique case (item_reg.op)
            OP_ADD:
            begin
                if (item_reg.endpoint[47:16] == '0)
                begin
                    result.status = ST_ZERO;
                end
                else if (found_reg)
                begin
                    result.status   = ST_DUP;
                    result.new_rank = hit_reg.rank;
                end
                else if (table_full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    result.status         = ST_OK;
                    result.probe_now      = 1'b1;
                    result.start_announce = !announcing_reg;
                    wr_en            = 1'b1;
                    wr_addr          = count_reg[IDX_W-1:0];
                    wr_entry.endpoint = item_reg.endpoint;
                    wr_entry.rank     = RANK_ZERO;
                    wr_entry.pending  = 1'b0;
                end
            end
            OP_SUCCESS:
            begin
                if (!found_reg)
                begin
                    result.status = ST_NOTFOUND;
                end
                else
                begin
                    rank_work = $signed(hit_reg.rank) + RANK_ONE;
                    if (rank_work > RANK_MAX)
                    begin
                        rank_work = RANK_MAX;
                    end
                    else if (rank_work < RANK_ONE)
                    begin
                        rank_work = RANK_ONE;
                    end
                    result.new_rank     = rank_work;
                    result.cancel_probe = hit_reg.pending;
                    wr_en            = 1'b1;
                    wr_entry.rank    = rank_work;
                    wr_entry.pending = 1'b0;
                end
            end
            OP_FAILURE:
            begin
                if (!found_reg)
                begin
                    result.status = ST_NOTFOUND;
                end
                else
                begin
                    rank_work = $signed(hit_reg.rank) - RANK_ONE;
                    if (rank_work < RANK_MIN)
                    begin
                        rank_work = RANK_MIN;
                    end
                    result.new_rank = rank_work;
                    wr_en         = 1'b1;
                    wr_entry.rank = rank_work;
                    if ((rank_work <= RANK_ZERO) && !hit_reg.pending)
                    begin
                        wr_entry.pending      = 1'b1;
                        result.probe_delay_ms = probe_delay(rank_work);
                    end
                end
            end
            OP_PROBE:
            begin
                if (!found_reg)
                begin
                    result.status = ST_NOTFOUND;
                end
                else
                begin
                    result.new_rank  = hit_reg.rank;
                    result.probe_now = hit_reg.pending;
                    wr_en            = 1'b1;
                    wr_entry.pending = 1'b0;
                end
            end
            OP_PICK:
            begin
                if (found_reg)
                begin
                    result.chosen_endpoint = hit_reg.endpoint;
                    result.new_rank        = hit_reg.rank;
                end
                else
                begin
                    result.status          = ST_NONE;
                    result.chosen_endpoint = '0;
                end
            end
            default:
            begin
                result.chosen_endpoint = '0;
            end
        endcase
        if (state_reg != S_FINISH || (rsp_valid_reg && rsp_stall))
        begin
            wr_en = 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        rd_idx_next     = issue ? rd_idx_reg + 1'b1 : rd_idx_reg;
        chk_valid_next  = issue;
        chk_idx_next    = rd_idx_reg[IDX_W-1:0];
        k_next          = k_reg;
        target_next     = target_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        count_next      = count_reg;
        announcing_next = announcing_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        div_start       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next   = req;
                    rd_idx_next = '0;
                    k_next      = '0;
                    found_next  = 1'b0;
                    priority if (req.op == OP_ADD && req.endpoint[47:16] == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (req.op == OP_ADD || req.op == OP_SUCCESS
                             || req.op == OP_FAILURE || req.op == OP_PROBE)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.op == OP_PICK)
                    begin
                        state_next = S_COUNT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = chk_idx_reg;
                    hit_next     = rd_entry;
                    state_next   = S_FINISH;
                end
                else if (scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_COUNT:
            begin
                if (eligible)
                begin
                    k_next = k_reg + 1'b1;
                end
                if (scan_end)
                begin
                    if (k_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (div_done)
                begin
                    target_next = div_rem;
                    rd_idx_next = '0;
                    k_next      = '0;
                    state_next  = S_SELECT;
                end
            end
            S_SELECT:
            begin
                if (eligible)
                begin
                    if (k_reg == target_reg)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = chk_idx_reg;
                        hit_next     = rd_entry;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else if (scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = result;
                    rsp_valid_next = 1'b1;
                    if (item_reg.op == OP_ADD && result.status == ST_OK)
                    begin
                        count_next      = count_reg + 1'b1;
                        announcing_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_idx_reg     <= '0;
            chk_valid_reg  <= 1'b0;
            k_reg          <= '0;
            found_reg      <= 1'b0;
            count_reg      <= '0;
            announcing_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            chk_valid_reg  <= chk_valid_next;
            k_reg          <= k_next;
            found_reg      <= found_next;
            count_reg      <= count_next;
            announcing_reg <= announcing_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        chk_idx_reg <= chk_idx_next;
        target_reg  <= target_next;
        hit_idx_reg <= hit_idx_next;
        hit_reg     <= hit_next;
        rsp_reg     <= rsp_next;
    end

    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign div_dividend = item_reg.random_value;
    assign div_divisor  = k_reg;

endmodule

// File: rtl/peer_health_rank_table_top.sv
// add, success, failure and probe scan the stored entries up to a hit or to the end of the table;
//   an add of a zero address skips the scan
// pick: two memory passes and a modulo; the modulo and second pass are skipped when none is eligible
// one item at a time, the next taken once the result is registered; output stalls add to latency
// reset clears entry count, announce flag and control; no memory clearing pass
// top level of the peer health rank table; instantiates phrt_ctrl, phrt_mem, phrt_div
module peer_health_rank_table_top #(
    parameter int TABLE_DEPTH  = phrt_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_EXCLUDES = phrt_pkg::MAX_EXCLUDES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  phrt_pkg::phrt_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output phrt_pkg::phrt_rsp_t  rsp
);
    import phrt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    phrt_entry_t        wr_entry;
    logic [IDX_W-1:0]   rd_addr;
    phrt_entry_t        rd_entry;
    logic               div_start;
    logic               div_done;
    logic [CNT_W-1:0]   div_rem;
    logic [CNT_W-1:0]   div_divisor;
    logic [31:0]        div_dividend;

    phrt_ctrl #(
        .DEPTH        (TABLE_DEPTH),
        .MAX_EXCLUDES (MAX_EXCLUDES),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_entry     (wr_entry),
        .rd_addr      (rd_addr),
        .rd_entry     (rd_entry),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_rem      (div_rem)
    );

    phrt_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    phrt_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

endmodule

// File: rtl/phrt_checker.sv
// port-level checks of the peer health rank table result channel
// attached to peer_health_rank_table_top by the bind below; uses phrt_pkg
module phrt_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_stall,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input phrt_pkg::phrt_rsp_t  rsp
);
    import phrt_pkg::*;

    // a stalled result transfer holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // an accepted request keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status <= ST_NONE)
                      && ($signed(rsp.new_rank) >= RANK_MIN)
                      && ($signed(rsp.new_rank) <= RANK_MAX))
        else $error("status or rank out of range");

    a_side_effects_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |->
            !rsp.probe_now && !rsp.cancel_probe && !rsp.start_announce
            && (rsp.probe_delay_ms == '0))
        else $error("probe action on failed operation");

    a_probe_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.probe_now && rsp.cancel_probe)
                      && !(rsp.cancel_probe && (rsp.probe_delay_ms != '0)))
        else $error("conflicting probe actions");

endmodule

bind peer_health_rank_table_top phrt_checker u_phrt_checker (.*);

// File: tb/sv/tb.sv
// testbench for peer_health_rank_table_top: a directed table of peer operations, then random ones
// each transfer is checked against its directed expectation or an in-bench model of the peer table
// depends on rtl/phrt_pkg.sv and rtl/peer_health_rank_table_top.sv
`timescale 1ns / 100ps

module tb;
    import phrt_pkg::*;

    localparam int  TABLE_DEPTH  = TABLE_DEPTH_DEF;
    localparam int  MAX_EXCLUDES = MAX_EXCLUDES_DEF;
    localparam int  RANDOM_OPS   = 1650;
    localparam int  MAX_REPORTS  = 10;
    localparam bit  TYPED        = 1'b1;
    localparam bit  PREDICTED    = 1'b0;
    localparam phrt_rsp_t NO_RSP = '0;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        phrt_req_t  req;
        logic       typed;
        phrt_rsp_t  rsp;
    } peer_case_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    phrt_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    phrt_rsp_t rsp;

    // model of the peer table
    logic [47:0]       peer_ep    [TABLE_DEPTH];
    logic signed [3:0] peer_rank  [TABLE_DEPTH];
    logic              peer_probe [TABLE_DEPTH];
    int                peer_count = 0;
    logic              announced  = 1'b0;

    phrt_rsp_t  peer_results_q [$];
    peer_case_t directed_cases [$];
    int         bad_results = 0;
    bit         calm        = 1'b0;

    peer_health_rank_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int find_peer(input logic [47:0] ep);
        for (int i = 0; i < peer_count; i++)
            if (peer_ep[i] == ep)
                return i;
        return -1;
    endfunction

    function automatic bit on_skip_list(input phrt_req_t r, input logic [47:0] ep);
        int n;
        n = (int'(r.exclude_count) > MAX_EXCLUDES) ? MAX_EXCLUDES : int'(r.exclude_count);
        return (n > 0 && r.exclude_a == ep) || (n > 1 && r.exclude_b == ep)
            || (n > 2 && r.exclude_c == ep);
    endfunction

    function automatic bit is_eligible(input phrt_req_t r, input int i);
        return peer_rank[i] > 0 && !on_skip_list(r, peer_ep[i]);
    endfunction

    function automatic phrt_rsp_t apply_peer_op(input phrt_req_t r);
        phrt_rsp_t o;
        int        idx;
        int        rk;
        int        k;
        int        target;
        int        seen;
        o = '0;
        o.status = ST_OK;
        o.chosen_endpoint = r.endpoint;
        idx = find_peer(r.endpoint);
        case (r.op)
            OP_ADD:
            begin
                if (r.endpoint[47:16] == 32'd0)
                    o.status = ST_ZERO;
                else if (idx >= 0)
                begin
                    o.status = ST_DUP;
                    o.new_rank = peer_rank[idx];
                end
                else if (peer_count >= TABLE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    peer_ep[peer_count] = r.endpoint;
                    peer_rank[peer_count] = RANK_ZERO;
                    peer_probe[peer_count] = 1'b0;
                    peer_count++;
                    o.start_announce = !announced;
                    announced = 1'b1;
                    o.probe_now = 1'b1;
                end
            end
            OP_SUCCESS, OP_FAILURE, OP_PROBE:
            begin
                if (idx < 0)
                    o.status = ST_NOTFOUND;
                else if (r.op == OP_SUCCESS)
                begin
                    rk = peer_rank[idx] + 1;
                    if (rk > RANK_MAX)
                        rk = RANK_MAX;
                    if (rk < RANK_ONE)
                        rk = RANK_ONE;
                    peer_rank[idx] = 4'(rk);
                    o.cancel_probe = peer_probe[idx];
                    peer_probe[idx] = 1'b0;
                    o.new_rank = 4'(rk);
                end
                else if (r.op == OP_FAILURE)
                begin
                    rk = peer_rank[idx] - 1;
                    if (rk < RANK_MIN)
                        rk = RANK_MIN;
                    peer_rank[idx] = 4'(rk);
                    if (rk <= 0 && !peer_probe[idx])
                    begin
                        peer_probe[idx] = 1'b1;
                        o.probe_delay_ms = 18'((1 - rk) * int'(PROBE_STEP_MS));
                    end
                    o.new_rank = 4'(rk);
                end
                else
                begin
                    o.probe_now = peer_probe[idx];
                    peer_probe[idx] = 1'b0;
                    o.new_rank = peer_rank[idx];
                end
            end
            OP_PICK:
            begin
                o.status = ST_NONE;
                o.chosen_endpoint = '0;
                k = 0;
                for (int i = 0; i < peer_count; i++)
                    if (is_eligible(r, i))
                        k++;
                if (k > 0)
                begin
                    target = int'(r.random_value % k);
                    seen = 0;
                    for (int i = 0; i < peer_count; i++)
                        if (is_eligible(r, i))
                        begin
                            if (seen == target)
                            begin
                                o.status = ST_OK;
                                o.chosen_endpoint = peer_ep[i];
                                o.new_rank = peer_rank[i];
                            end
                            seen++;
                        end
                end
            end
            default:
                o = '0;
        endcase
        return o;
    endfunction

    function automatic phrt_req_t mk_req(input logic [2:0] op, input logic [47:0] ep,
                                         input logic [1:0] nex, input logic [47:0] xa,
                                         input logic [47:0] xb, input logic [47:0] xc,
                                         input logic [31:0] rnd);
        phrt_req_t r;
        r.op = op;
        r.endpoint = ep;
        r.exclude_count = nex;
        r.exclude_a = xa;
        r.exclude_b = xb;
        r.exclude_c = xc;
        r.random_value = rnd;
        return r;
    endfunction

    function automatic phrt_rsp_t mk_rsp(input logic [2:0] st, input logic [47:0] ep,
                                         input logic signed [3:0] rk, input logic pnow,
                                         input logic ann);
        phrt_rsp_t o;
        o = '0;
        o.status = st;
        o.chosen_endpoint = ep;
        o.new_rank = rk;
        o.probe_now = pnow;
        o.start_announce = ann;
        return o;
    endfunction

    function automatic logic [47:0] rand_ep();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] known_ep();
        if (peer_count > 0 && $urandom_range(99) < 85)
            return peer_ep[$urandom_range(peer_count - 1)];
        return rand_ep();
    endfunction

    task automatic issue_peer_op(input phrt_req_t item, input logic typed,
                                 input phrt_rsp_t typed_rsp);
        phrt_rsp_t predicted;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 26)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = apply_peer_op(item);
        peer_results_q.push_back(typed ? typed_rsp : predicted);
    endtask

    always @(negedge clk)
        rsp_stall <= !calm && ($urandom_range(99) < 26);

    always @(posedge clk)
    begin
        phrt_rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
        begin
            if (peer_results_q.size() == 0)
            begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("unexpected transfer: status %0d ep %h", rsp.status,
                             rsp.chosen_endpoint);
            end
            else
            begin
                want = peer_results_q.pop_front();
                if (rsp.status !== want.status || rsp.chosen_endpoint !== want.chosen_endpoint
                    || rsp.new_rank !== want.new_rank || rsp.probe_now !== want.probe_now
                    || rsp.probe_delay_ms !== want.probe_delay_ms
                    || rsp.cancel_probe !== want.cancel_probe
                    || rsp.start_announce !== want.start_announce)
                begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display({"mismatch (exp/got): status %0d/%0d ep %h/%h rank %0d/%0d",
                                  " now %0b/%0b delay %0d/%0d cancel %0b/%0b ann %0b/%0b"},
                                 want.status, rsp.status, want.chosen_endpoint,
                                 rsp.chosen_endpoint, want.new_rank, rsp.new_rank,
                                 want.probe_now, rsp.probe_now, want.probe_delay_ms,
                                 rsp.probe_delay_ms, want.cancel_probe, rsp.cancel_probe,
                                 want.start_announce, rsp.start_announce);
                end
            end
        end
    end

    initial
    begin
        logic [47:0] ep_a;
        logic [47:0] ep_b;
        logic [47:0] ep_c;
        logic [47:0] ep_z;
        logic [47:0] ones;
        phrt_req_t   r;
        int          fail_w;
        int          roll;
        ep_a = 48'hC0A8_0001_1F90;
        ep_b = 48'hFFFF_FFFF_FFFF;
        ep_c = 48'h0000_0001_0000;
        ep_z = 48'h0000_0000_FFFF;
        ones = 48'hFFFF_FFFF_FFFF;

        directed_cases.push_back({mk_req(OP_PICK, '0, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_NONE, '0, RANK_ZERO, 1'b0, 1'b0)});
        directed_cases.push_back({mk_req(OP_SUCCESS, ep_a, 2'd3, ones, ones, ones, '1), TYPED,
                                  mk_rsp(ST_NOTFOUND, ep_a, RANK_ZERO, 1'b0, 1'b0)});
        directed_cases.push_back({mk_req(OP_FAILURE, ep_a, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_NOTFOUND, ep_a, RANK_ZERO, 1'b0, 1'b0)});
        directed_cases.push_back({mk_req(OP_PROBE, ep_a, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_NOTFOUND, ep_a, RANK_ZERO, 1'b0, 1'b0)});
        directed_cases.push_back({mk_req(OP_ADD, ep_z, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_ZERO, ep_z, RANK_ZERO, 1'b0, 1'b0)});
        directed_cases.push_back({mk_req(OP_ADD, '0, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_ZERO, '0, RANK_ZERO, 1'b0, 1'b0)});
        directed_cases.push_back({mk_req(OP_ADD, ep_a, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_OK, ep_a, RANK_ZERO, 1'b1, 1'b1)});
        directed_cases.push_back({mk_req(OP_ADD, ep_a, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_DUP, ep_a, RANK_ZERO, 1'b0, 1'b0)});
        directed_cases.push_back({mk_req(OP_ADD, ep_b, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_OK, ep_b, RANK_ZERO, 1'b1, 1'b0)});
        directed_cases.push_back({mk_req(OP_ADD, ep_c, 2'd0, '0, '0, '0, '0), TYPED,
                                  mk_rsp(ST_OK, ep_c, RANK_ZERO, 1'b1, 1'b0)});
        directed_cases.push_back({mk_req(OP_PICK, '0, 2'd0, '0, '0, '0, '1), TYPED,
                                  mk_rsp(ST_NONE, '0, RANK_ZERO, 1'b0, 1'b0)});
        // failure schedules a probe, a second failure finds it pending, success cancels it
        directed_cases.push_back({mk_req(OP_FAILURE, ep_a, 2'd0, '0, '0, '0, '0), PREDICTED,
                                  NO_RSP});
        directed_cases.push_back({mk_req(OP_FAILURE, ep_a, 2'd0, '0, '0, '0, '0), PREDICTED,
                                  NO_RSP});
        directed_cases.push_back({mk_req(OP_SUCCESS, ep_a, 2'd0, '0, '0, '0, '0), PREDICTED,
                                  NO_RSP});
        directed_cases.push_back({mk_req(OP_FAILURE, ep_a, 2'd0, '0, '0, '0, '0), PREDICTED,
                                  NO_RSP});
        directed_cases.push_back({mk_req(OP_PROBE, ep_a, 2'd0, '0, '0, '0, '0), PREDICTED,
                                  NO_RSP});
        directed_cases.push_back({mk_req(OP_PROBE, ep_a, 2'd0, '0, '0, '0, '0), PREDICTED,
                                  NO_RSP});
        repeat (6)
            directed_cases.push_back({mk_req(OP_SUCCESS, ep_b, 2'd0, '0, '0, '0, '0),
                                      PREDICTED, NO_RSP});
        directed_cases.push_back({mk_req(OP_SUCCESS, ep_c, 2'd0, '0, '0, '0, '0), PREDICTED,
                                  NO_RSP});
        directed_cases.push_back({mk_req(OP_PICK, '0, 2'd3, ep_b, ep_a, ep_c, '1), TYPED,
                                  mk_rsp(ST_NONE, '0, RANK_ZERO, 1'b0, 1'b0)});
        directed_cases.push_back({mk_req(OP_PICK, ones, 2'd0, ep_b, ep_a, ep_c, '1), PREDICTED,
                                  NO_RSP});
        directed_cases.push_back({mk_req(OP_UNUSED, ones, 2'd3, ones, ones, ones, '1), TYPED,
                                  NO_RSP});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_cases[i])
            issue_peer_op(directed_cases[i].req, directed_cases[i].typed,
                          directed_cases[i].rsp);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            calm = (i >= 500 && i < 800);
            if (i == 800)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                while (peer_results_q.size() != 0)
                    @(posedge clk);
            end
            // alternate failure-heavy and success-heavy stretches to reach both rank limits
            fail_w = (i % 200 < 100) ? 45 : 15;
            r = mk_req(3'($urandom), rand_ep(), 2'($urandom), rand_ep(), rand_ep(), rand_ep(),
                       $urandom);
            roll = $urandom_range(99);
            if (roll < 10)
            begin
                r.op = OP_ADD;
                roll = $urandom_range(99);
                if (roll < 5)
                    r.endpoint = {32'd0, 16'($urandom)};
                else if (roll >= 55)
                    r.endpoint = known_ep();
            end
            else if (roll < 97)
            begin
                if (roll < 10 + fail_w)
                    r.op = OP_FAILURE;
                else if (roll < 30 + fail_w)
                    r.op = OP_SUCCESS;
                else if (roll < 87)
                    r.op = OP_PICK;
                else
                    r.op = OP_PROBE;
                r.endpoint = known_ep();
                if (r.op == OP_PICK)
                begin
                    r.exclude_a = known_ep();
                    r.exclude_b = known_ep();
                    r.exclude_c = known_ep();
                    if ($urandom_range(1) == 0)
                        r.random_value = $urandom_range(31);
                end
            end
            else if (r.op < 3'd5)
                r.op = OP_UNUSED;
            issue_peer_op(r, PREDICTED, NO_RSP);
        end
        calm = 1'b0;
        @(negedge clk);
        req_valid <= 1'b0;

        while (peer_results_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (bad_results == 0 && peer_results_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/phrt_pkg.sv
rtl/phrt_mem.sv
rtl/phrt_div.sv
rtl/phrt_ctrl.sv
rtl/peer_health_rank_table_top.sv
rtl/phrt_checker.sv
tb/sv/tb.sv
